// File: hw/rtl/xcfp_pkg.sv
package xcfp_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_PAYLOAD_DEF   = 32;
	localparam int TABLE_ENTRIES_DEF = 4;

	// Configuration port
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_HEADER = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TAIL   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COUNT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TABLE0 = 3'd3;

	localparam logic [7:0] HEADER_RST = 8'h7A;
	localparam logic [7:0] TAIL_RST   = 8'h7B;

	localparam int COUNT_W = 3;
	localparam int ENTRY_W = 16;

	// Frame descriptor queue between parser and emitter
	localparam int QUEUE_DEPTH = 2;
	localparam int SLOT_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [SLOT_W-1:0] wr_slot;
		logic [SLOT_W-1:0] rd_slot;
	} qstat_t;

	// Index width into one payload bank
	function automatic int idx_width(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// File: hw/rtl/xcfp_if.sv
interface xcfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfp_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] func_code;
	logic [7:0] payload_byte;
	logic [4:0] byte_index;
	logic       has_data;
	logic       last;

	modport source (output valid, output func_code, output payload_byte,
		output byte_index, output has_data, output last, input ready);
	modport sink (input valid, input func_code, input payload_byte,
		input byte_index, input has_data, input last, output ready);
endinterface

// File: hw/rtl/xcfp_front.sv
module xcfp_front import xcfp_pkg::*; #(
	parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF,
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1),
	localparam int IDX_W  = idx_width(MAX_PAYLOAD),
	localparam int ADDR_W = IDX_W + SLOT_W,
	localparam int DESC_W = 8 + LEN_W
) (
	input  logic               clk,
	input  logic               arst_n,
	xcfp_rx_if.sink            rx,
	input  logic [7:0]         header_byte,
	input  logic [7:0]         tail_byte,
	input  logic [COUNT_W-1:0] entry_count,
	input  logic [ENTRY_W-1:0] table_entry [TABLE_ENTRIES],
	input  qstat_t             q_stat,
	output logic               push,
	output logic [DESC_W-1:0]  push_data,
	output logic               mem_we,
	output logic [ADDR_W-1:0]  mem_addr,
	output logic [7:0]         mem_wdata
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_CODE = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_TAIL = 2'd3;

	logic [1:0]       phase_q;
	logic [7:0]       code_q;
	logic [LEN_W-1:0] exp_len_q;
	logic [LEN_W-1:0] count_q;
	logic [7:0]       xor_q;
	logic [7:0]       saved_q;

	logic       accept;
	logic       found;
	logic [7:0] len8;
	logic       known;
	logic       in_body;

	assign rx.ready = !q_stat.full;
	assign accept   = rx.valid && rx.ready;

	// first matching entry wins
	always_comb begin
		found = 1'b0;
		len8  = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (!found && (COUNT_W'(i) < entry_count) &&
			    (table_entry[i][15:8] == rx.rx_byte)) begin
				found = 1'b1;
				len8  = table_entry[i][7:0];
			end
		end
	end

	assign known   = found && (len8 <= 8'(MAX_PAYLOAD));
	assign in_body = (count_q < exp_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			code_q    <= '0;
			exp_len_q <= '0;
			count_q   <= '0;
			xor_q     <= '0;
			saved_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx.rx_byte == header_byte) begin
						xor_q   <= rx.rx_byte;
						phase_q <= PH_CODE;
					end
				end
				PH_CODE: begin
					if (known) begin
						code_q    <= rx.rx_byte;
						exp_len_q <= len8[LEN_W-1:0];
						count_q   <= '0;
						xor_q     <= xor_q ^ rx.rx_byte;
						phase_q   <= PH_BODY;
					end else if (rx.rx_byte == header_byte) begin
						xor_q   <= rx.rx_byte;
						phase_q <= PH_CODE;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_BODY: begin
					if (in_body) begin
						xor_q   <= xor_q ^ rx.rx_byte;
						count_q <= count_q + LEN_W'(1);
					end else begin
						saved_q <= rx.rx_byte;
						phase_q <= PH_TAIL;
					end
				end
				PH_TAIL: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	assign mem_we    = accept && (phase_q == PH_BODY) && in_body;
	assign mem_addr  = {q_stat.wr_slot, count_q[IDX_W-1:0]};
	assign mem_wdata = rx.rx_byte;

	assign push = accept && (phase_q == PH_TAIL) && (saved_q == xor_q) &&
		(rx.rx_byte == tail_byte);
	assign push_data = {code_q, exp_len_q};

endmodule

// File: hw/rtl/xcfp_queue.sv
module xcfp_queue import xcfp_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head_data,
	output qstat_t       stat
);

	logic [W-1:0]      data_q [QUEUE_DEPTH];
	logic [SLOT_W-1:0] wr_q;
	logic [SLOT_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + SLOT_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + SLOT_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= push_data;
		end
	end

	assign head_data    = data_q[rd_q];
	assign stat.full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty   = (cnt_q == '0);
	assign stat.wr_slot = wr_q;
	assign stat.rd_slot = rd_q;

endmodule

// File: hw/rtl/xcfp_back.sv
module xcfp_back import xcfp_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1),
	localparam int IDX_W  = idx_width(MAX_PAYLOAD),
	localparam int ADDR_W = IDX_W + SLOT_W,
	localparam int DESC_W = 8 + LEN_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mem_we,
	input  logic [ADDR_W-1:0] mem_addr,
	input  logic [7:0]        mem_wdata,
	input  logic [DESC_W-1:0] head_data,
	input  qstat_t            q_stat,
	output logic              pop,
	xcfp_res_if.source        res
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_READ = 2'd1;
	localparam logic [1:0] B_SHOW = 2'd2;

	logic [7:0]       payload_mem_q [2**ADDR_W];
	logic [7:0]       rd_data_q;
	logic [1:0]       state_q;
	logic [IDX_W-1:0] k_q;

	logic [7:0]       head_code;
	logic [LEN_W-1:0] head_len;
	logic [LEN_W-1:0] k_len;
	logic [IDX_W+4:0] k_wide;
	logic             is_last;

	assign head_code = head_data[DESC_W-1 -: 8];
	assign head_len  = head_data[LEN_W-1:0];
	assign k_len     = LEN_W'(k_q);
	assign k_wide    = (IDX_W + 5)'(k_q);
	assign is_last   = (head_len == '0) || ((k_len + LEN_W'(1)) == head_len);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			payload_mem_q[mem_addr] <= mem_wdata;
		end
		if (state_q == B_READ) begin
			rd_data_q <= payload_mem_q[{q_stat.rd_slot, k_q}];
		end
	end

	// head entry stays queued until its last result goes out, so its bank
	// cannot be refilled while it is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						k_q     <= '0;
						state_q <= B_READ;
					end
				end
				B_READ: begin
					state_q <= B_SHOW;
				end
				B_SHOW: begin
					if (res.ready) begin
						if (is_last) begin
							state_q <= B_IDLE;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= B_READ;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign pop              = (state_q == B_SHOW) && res.ready && is_last;
	assign res.valid        = (state_q == B_SHOW);
	assign res.func_code    = head_code;
	assign res.has_data     = (head_len != '0);
	assign res.payload_byte = res.has_data ? rd_data_q : 8'h00;
	assign res.byte_index   = k_wide[4:0];
	assign res.last         = is_last;

endmodule

// File: hw/rtl/xor_checked_frame_parser.sv
// Serial frame parser: takes one received byte per rx transfer, hunts for the
// header byte, looks the following function code up in a table of up to
// TABLE_ENTRIES (code, length) pairs (first match wins, lengths above
// MAX_PAYLOAD count as unknown), stores the payload, then checks an XOR check
// byte (header ^ code ^ payload) and the tail byte. A good frame comes out on
// res as one transfer per payload byte with code, index and last flag, or as
// one transfer with has_data clear when the length is zero; bad frames vanish.
// The parser takes one byte every clock as long as the two-entry frame queue
// has room; it stalls rx only while two good frames wait for the emitter. For
// each result the emitter reads the payload memory, then holds the output
// until res takes it; after the last result it goes idle before picking up
// the next frame. The payload memory holds two banks of MAX_PAYLOAD bytes,
// one per queue entry. Configuration registers sit on the APB port (header,
// tail, entry count, table entries at 4-byte steps); the user must write
// them only while the block is idle, and the block itself does not enforce it.
module xor_checked_frame_parser import xcfp_pkg::*; #(
	parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF,
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	xcfp_rx_if.sink            rx,
	xcfp_res_if.source         res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W  = idx_width(MAX_PAYLOAD);
	localparam int ADDR_W = IDX_W + SLOT_W;
	localparam int DESC_W = 8 + LEN_W;

	// Configuration registers
	logic [7:0]         header_q;
	logic [7:0]         tail_q;
	logic [COUNT_W-1:0] count_q;
	logic [ENTRY_W-1:0] table_q [TABLE_ENTRIES];

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	// Parser to queue to emitter
	qstat_t            q_stat;
	logic              push;
	logic [DESC_W-1:0] push_data;
	logic              pop;
	logic [DESC_W-1:0] head_data;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        mem_wdata;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RST;
			tail_q   <= TAIL_RST;
			count_q  <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				table_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			if (reg_idx == REG_HEADER) begin
				header_q <= pwdata[7:0];
			end
			if (reg_idx == REG_TAIL) begin
				tail_q <= pwdata[7:0];
			end
			if (reg_idx == REG_COUNT) begin
				count_q <= pwdata[COUNT_W-1:0];
			end
			// table slots past TABLE_ENTRIES are not stored; drop the write
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (reg_idx == REG_TABLE0 + REG_IDX_W'(i)) begin
					table_q[i] <= pwdata[ENTRY_W-1:0];
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_HEADER: prdata = PDATA_W'(header_q);
			REG_TAIL:   prdata = PDATA_W'(tail_q);
			REG_COUNT:  prdata = PDATA_W'(count_q);
			default:    prdata = '0;
		endcase
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (reg_idx == REG_TABLE0 + REG_IDX_W'(i)) begin
				prdata = PDATA_W'(table_q[i]);
			end
		end
	end

	// Front: byte parser, writes payload into the free bank
	xcfp_front #(
		.MAX_PAYLOAD   (MAX_PAYLOAD),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.header_byte (header_q),
		.tail_byte   (tail_q),
		.entry_count (count_q),
		.table_entry (table_q),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data),
		.mem_we      (mem_we),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata)
	);

	// Queue of good frames; slot number doubles as payload bank
	xcfp_queue #(
		.W (DESC_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.stat      (q_stat)
	);

	// Back: walks the head frame's bank and hands out results
	xcfp_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.head_data (head_data),
		.q_stat    (q_stat),
		.pop       (pop),
		.res       (res)
	);

	// Parser never writes into a bank that still holds a queued frame
	a_bank_free: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (q_stat.empty || (mem_addr[ADDR_W-1] != q_stat.rd_slot)))
		else $error("payload write hits a queued bank");

	// A good frame is only queued when there is room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("frame pushed into full queue");

	// Results only come from a queued frame
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !q_stat.empty)
		else $error("result without queued frame");

	// An empty-payload result is the whole frame
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.has_data) |-> res.last)
		else $error("empty frame result without last");

endmodule

// File: verif/xcfp_tb_pkg.sv
`timescale 1ns / 100ps
package xcfp_tb_pkg;
	import xcfp_pkg::*;

	typedef enum logic [1:0] {
		SEEK_HEADER,
		SEEK_CODE,
		TAKE_BODY,
		SEEK_TAIL
	} parse_step_t;

	typedef struct packed {
		logic [7:0] code;
		logic [7:0] data;
		logic [4:0] index;
		logic       has_data;
		logic       last;
	} frame_result_t;

	// Tracks the parser from the accepted bytes and holds the results it owes.
	class frame_ledger;
		logic [7:0]    header_val;
		logic [7:0]    tail_val;
		logic [2:0]    count_val;
		logic [15:0]   entry_val [TABLE_ENTRIES_DEF];
		parse_step_t   step;
		logic [7:0]    code;
		int unsigned   want_len;
		int unsigned   got_len;
		logic [7:0]    xor_acc;
		logic [7:0]    check_byte;
		logic [7:0]    body [MAX_PAYLOAD_DEF];
		frame_result_t due_results [$];
		int unsigned   bad_results;
		int unsigned   good_results;

		function new();
			header_val = HEADER_RST;
			tail_val = TAIL_RST;
			count_val = '0;
			foreach (entry_val[i])
				entry_val[i] = '0;
			step = SEEK_HEADER;
			code = '0;
			want_len = 0;
			got_len = 0;
			xor_acc = '0;
			check_byte = '0;
			bad_results = 0;
			good_results = 0;
		endfunction

		function void set_register(input logic [REG_IDX_W-1:0] idx,
				input logic [PDATA_W-1:0] value);
			case (idx)
				REG_HEADER: header_val = value[7:0];
				REG_TAIL:   tail_val = value[7:0];
				REG_COUNT:  count_val = value[COUNT_W-1:0];
				default:    entry_val[idx - REG_TABLE0] = value[ENTRY_W-1:0];
			endcase
		endfunction

		// First matching entry wins; lengths beyond the payload store are unknown.
		function bit find_length(input logic [7:0] c, output int unsigned len);
			int unsigned n;
			n = (count_val > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : 32'(count_val);
			len = 0;
			for (int i = 0; i < n; i++) begin
				if (entry_val[i][15:8] == c) begin
					len = 32'(entry_val[i][7:0]);
					return (len <= MAX_PAYLOAD_DEF);
				end
			end
			return 1'b0;
		endfunction

		function void take_rx_byte(input logic [7:0] b);
			int unsigned   len;
			frame_result_t r;
			case (step)
				SEEK_HEADER: begin
					if (b == header_val) begin
						xor_acc = b;
						step = SEEK_CODE;
					end
				end
				SEEK_CODE: begin
					if (find_length(b, len)) begin
						code = b;
						want_len = len;
						got_len = 0;
						xor_acc ^= b;
						step = TAKE_BODY;
					end else if (b == header_val) begin
						xor_acc = b;
					end else begin
						step = SEEK_HEADER;
					end
				end
				TAKE_BODY: begin
					if (got_len < want_len) begin
						body[got_len] = b;
						xor_acc ^= b;
						got_len++;
					end else begin
						check_byte = b;
						step = SEEK_TAIL;
					end
				end
				default: begin
					step = SEEK_HEADER;
					if (check_byte == xor_acc && b == tail_val) begin
						if (want_len == 0) begin
							r.code = code;
							r.data = 8'h00;
							r.index = 5'd0;
							r.has_data = 1'b0;
							r.last = 1'b1;
							due_results.push_back(r);
						end else begin
							for (int k = 0; k < want_len; k++) begin
								r.code = code;
								r.data = body[k];
								r.index = k[4:0];
								r.has_data = 1'b1;
								r.last = (k + 1 == want_len);
								due_results.push_back(r);
							end
						end
					end
				end
			endcase
		endfunction

		function void note_error(input string what, input frame_result_t want,
				input frame_result_t got);
			bad_results++;
			if (bad_results <= 10)
				$display({"ERROR at %0t: %s: code %h/%h data %h/%h index %0d/%0d ",
					"has_data %b/%b last %b/%b (expected/actual)"},
					$time, what, want.code, got.code, want.data, got.data,
					want.index, got.index, want.has_data, got.has_data,
					want.last, got.last);
		endfunction

		function void compare_result(input frame_result_t got);
			frame_result_t want;
			if (due_results.size() == 0) begin
				note_error("transfer with no frame result pending", '0, got);
				return;
			end
			want = due_results.pop_front();
			if (got.code !== want.code || got.data !== want.data ||
					got.index !== want.index || got.has_data !== want.has_data ||
					got.last !== want.last)
				note_error("result mismatch", want, got);
			else
				good_results++;
		endfunction

		function void flush_due();
			if (due_results.size() != 0) begin
				bad_results += due_results.size();
				$display("ERROR: %0d frame results never arrived", due_results.size());
				due_results.delete();
			end
		endfunction
	endclass

endpackage

// File: verif/tb_xor_checked_frame_parser.sv
`timescale 1ns / 100ps
module tb_xor_checked_frame_parser;
	import xcfp_pkg::*;
	import xcfp_tb_pkg::*;

	localparam int RX_TARGET  = 270;                      // random bytes to send
	localparam int PHASE_LEN  = 50;                       // bytes per register setting
	localparam int QUIET_TAIL = 40;                       // final bytes with no idling
	localparam int SETTLE     = 2 * MAX_PAYLOAD_DEF + 16; // emitter drain plus slack

	typedef enum int {
		GOOD_FRAME,
		BAD_CHECK,
		BAD_TAIL,
		HEADER_IN_BODY
	} frame_kind_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	xcfp_rx_if  rx_ch ();
	xcfp_res_if res_ch ();

	frame_ledger ledger = new();
	int unsigned rx_count;
	int unsigned reg_writes;
	int unsigned stall_left;
	bit          quiet;

	xor_checked_frame_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// Result side: check every accepted transfer against the oldest pending
	// result, then decide whether ready stalls for the next few cycles.
	always @(posedge clk) begin
		frame_result_t got;
		if (!arst_n) begin
			stall_left = 0;
			res_ch.ready <= 1'b1;
		end else begin
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.code = res_ch.func_code;
				got.data = res_ch.payload_byte;
				got.index = res_ch.byte_index;
				got.has_data = res_ch.has_data;
				got.last = res_ch.last;
				ledger.compare_result(got);
			end
			// Hold ready low for the burst, raise it again on the last stalled edge.
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					res_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 9);
				res_ch.ready <= 1'b0;
			end
		end
	end

	// Send one byte: maybe idle a burst first, then hold valid until the
	// transfer, and only then let the ledger see the byte.
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		ledger.take_rx_byte(b);
		rx_count++;
	endtask

	// Build a frame around the current header and tail; the kind decides
	// which part gets broken, if any.
	task automatic send_frame(input logic [7:0] code, input int unsigned len,
			input frame_kind_t kind);
		logic [7:0] acc;
		logic [7:0] b;
		acc = ledger.header_val ^ code;
		send_byte(ledger.header_val);
		send_byte(code);
		for (int unsigned i = 0; i < len; i++) begin
			b = (kind == HEADER_IN_BODY && i == 0) ? ledger.header_val : 8'($urandom);
			acc ^= b;
			send_byte(b);
		end
		if (kind == BAD_CHECK)
			acc ^= 8'(1 << $urandom_range(0, 7));
		send_byte(acc);
		send_byte(kind == BAD_TAIL ? ~ledger.tail_val : ledger.tail_val);
	endtask

	// APB write: setup, access, then idle with psel low so the next write never
	// lowers and raises psel in the same step.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ledger.set_register(idx, value);
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] hdr, input logic [7:0] tl,
			input logic [2:0] cnt, input logic [15:0] ent [TABLE_ENTRIES_DEF]);
		write_reg(REG_HEADER, PDATA_W'(hdr));
		write_reg(REG_TAIL, PDATA_W'(tl));
		write_reg(REG_COUNT, PDATA_W'(cnt));
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
			write_reg(REG_IDX_W'(REG_TABLE0 + i), PDATA_W'(ent[i]));
	endtask

	// Drop valid, wait for every pending result, then give a dropped frame
	// or a draining emitter time to finish before touching registers.
	task automatic settle();
		rx_ch.valid <= 1'b0;
		for (int t = 0; t < 40000 && ledger.due_results.size() != 0; t++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Random table: mostly short payloads, now and then the full store or an
	// oversize length; the first two settings pin the byte extremes.
	task automatic random_settings(input int unsigned phase);
		logic [15:0]  ent [TABLE_ENTRIES_DEF];
		logic [7:0]   hdr;
		logic [7:0]   tl;
		logic [2:0]   cnt;
		int unsigned  pick;
		hdr = 8'($urandom);
		tl = 8'($urandom);
		cnt = 3'($urandom_range(1, 7));
		foreach (ent[i]) begin
			pick = $urandom_range(0, 9);
			ent[i][15:8] = 8'($urandom);
			if (pick < 7)
				ent[i][7:0] = 8'($urandom_range(0, 6));
			else if (pick == 7)
				ent[i][7:0] = 8'(MAX_PAYLOAD_DEF);
			else if (pick == 8)
				ent[i][7:0] = 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255));
			else
				ent[i][7:0] = 8'($urandom_range(7, MAX_PAYLOAD_DEF - 1));
		end
		// Repeat a code now and then so the first match has to win.
		if ($urandom_range(0, 3) == 0)
			ent[1][15:8] = ent[0][15:8];
		if (phase == 0) begin
			hdr = 8'h00;
			tl = 8'hFF;
			cnt = 3'd4;
			ent[3] = 16'hFFFF;
		end else if (phase == 1) begin
			hdr = 8'hFF;
			tl = 8'h00;
			cnt = 3'd7;
			ent[0] = 16'h0000;
		end
		load_settings(hdr, tl, cnt, ent);
	endtask

	// One random chunk: mostly good frames on a known code, some broken
	// ones, some noise and stray headers.
	task automatic random_burst();
		int unsigned pick;
		int unsigned len;
		int unsigned n;
		logic [7:0]  c;
		pick = $urandom_range(0, 19);
		n = (ledger.count_val > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF :
			32'(ledger.count_val);
		c = ledger.entry_val[$urandom_range(0, n - 1)][15:8];
		if (!ledger.find_length(c, len))
			len = 0;
		if (pick < 13)
			send_frame(c, len, GOOD_FRAME);
		else if (pick == 13)
			send_frame(c, len, HEADER_IN_BODY);
		else if (pick == 14)
			send_frame(c, len, BAD_CHECK);
		else if (pick == 15)
			send_frame(c, len, BAD_TAIL);
		else if (pick < 18) begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
		end else begin
			send_byte(ledger.header_val);
			send_byte(8'($urandom));
		end
	endtask

	initial begin
		logic [15:0] ent [TABLE_ENTRIES_DEF];
		int unsigned total;
		int unsigned phase_end;
		int unsigned phase;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		quiet = 1'b0;
		rx_count = 0;
		reg_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table after reset: a header and any code lead nowhere.
		send_byte(HEADER_RST);
		send_byte(HEADER_RST);
		send_byte(8'h00);
		settle();

		// Count above the table size; code A5 is listed twice, the first
		// entry (empty payload) wins; 3C asks for more than the store holds.
		ent[0] = 16'hA500;
		ent[1] = 16'h5A01;
		ent[2] = 16'hA503;
		ent[3] = {8'h3C, 8'(MAX_PAYLOAD_DEF + 1)};
		load_settings(HEADER_RST, TAIL_RST, 3'd7, ent);
		send_byte(HEADER_RST);
		send_byte(8'h3C);
		// Header in the code slot restarts the frame, then an empty frame.
		send_byte(HEADER_RST);
		send_frame(8'hA5, 0, GOOD_FRAME);
		// Header byte inside the payload is plain data.
		send_frame(8'h5A, 1, HEADER_IN_BODY);
		send_frame(8'h5A, 1, BAD_TAIL);
		send_frame(8'h5A, 1, BAD_CHECK);

		// Random phases, each under a fresh register setting.
		total = rx_count + RX_TARGET;
		phase = 0;
		while (rx_count < total) begin
			settle();
			random_settings(phase);
			phase++;
			quiet = ($urandom_range(0, 3) == 0);
			phase_end = rx_count + PHASE_LEN;
			while (rx_count < phase_end && rx_count < total) begin
				if (rx_count + QUIET_TAIL >= total)
					quiet = 1'b1;
				random_burst();
			end
		end

		settle();
		ledger.flush_due();
		$display("Run covered %0d received bytes under %0d register settings (%0d writes).",
			rx_count, phase + 2, reg_writes);
		$display("Matched %0d result transfers; %0d errors.",
			ledger.good_results, ledger.bad_results);
		if (ledger.bad_results == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
